### sv/software_timer_table_top_defines.svh
// ----------------------------------------------------------------------------
// Software timer table: assertion macros
// Shared assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold in the same cycle as its antecedent.
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Property that must hold in the cycle after its antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STT_ASSERT_SAME(lbl, ante, cons, msg)
`define STT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Shared types, codes and helpers for the timer table controller and datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned DELAY_W   = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TICK   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_IDLE      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MARK_RD,
    ST_MARK_EV,
    ST_PACK_CHK,
    ST_PACK_RD,
    ST_PACK_EV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] deadline;
    logic [DELAY_W-1:0]   interval;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic add_commit;
    logic add_full;
    logic clear_all;
    logic scan_init;
    logic rd_en;
    logic mark_step;
    logic pack_init;
    logic pack_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    out_free;
    logic    count_zero;
    logic    count_full;
    logic    idx_zero;
    logic    idx_top;
    logic    gone_any;
    logic    mark_stall;
  } sts_t;

  // Time plus an offset, saturating at the largest time value.
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [DELAY_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + {{(TIME_BITS + 1 - DELAY_W){1'b0}}, d};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

### sv/stt_ram.sv
// ----------------------------------------------------------------------------
// Software timer table: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                            wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Software timer table: controller
// Sequences adds, clears, the marking scan and the compaction pass.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  stt_pkg::sts_t sts_i,
  output stt_pkg::cmd_t cmd_o
);

  stt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = stt_pkg::ST_DISPATCH;
        end
      end
      stt_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          stt_pkg::OP_ADD: begin
            if (sts_i.out_free) begin
              cmd_o.add_full   = sts_i.count_full;
              cmd_o.add_commit = !sts_i.count_full;
              state_d          = stt_pkg::ST_IDLE;
            end
          end
          stt_pkg::OP_CLEAR: begin
            if (sts_i.out_free) begin
              cmd_o.clear_all = 1'b1;
              state_d         = stt_pkg::ST_IDLE;
            end
          end
          stt_pkg::OP_CANCEL, stt_pkg::OP_TICK: begin
            if (sts_i.count_zero) begin
              state_d = stt_pkg::ST_FINISH;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = stt_pkg::ST_MARK_RD;
            end
          end
          default: state_d = stt_pkg::ST_IDLE;
        endcase
      end
      stt_pkg::ST_MARK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = stt_pkg::ST_MARK_EV;
      end
      stt_pkg::ST_MARK_EV: begin
        if (!sts_i.mark_stall) begin
          cmd_o.mark_step = 1'b1;
          state_d = sts_i.idx_zero ? stt_pkg::ST_PACK_CHK : stt_pkg::ST_MARK_RD;
        end
      end
      stt_pkg::ST_PACK_CHK: begin
        if (sts_i.gone_any) begin
          cmd_o.pack_init = 1'b1;
          state_d         = stt_pkg::ST_PACK_RD;
        end else begin
          state_d = stt_pkg::ST_FINISH;
        end
      end
      stt_pkg::ST_PACK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = stt_pkg::ST_PACK_EV;
      end
      stt_pkg::ST_PACK_EV: begin
        cmd_o.pack_step = 1'b1;
        state_d = sts_i.idx_top ? stt_pkg::ST_FINISH : stt_pkg::ST_PACK_RD;
      end
      stt_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = stt_pkg::ST_IDLE;
        end
      end
      default: state_d = stt_pkg::ST_IDLE;
    endcase
  end

endmodule

### sv/stt_datapath.sv
// ----------------------------------------------------------------------------
// Software timer table: datapath
// Item register, table RAM, scan pointers, removal marks and output register.
// ----------------------------------------------------------------------------
module stt_datapath #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [143:0]  s_axis_tdata_i,
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [31:0]   m_axis_tdata_o,
  output logic [2:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o,
  input  stt_pkg::cmd_t cmd_i,
  output stt_pkg::sts_t sts_o,
  output logic [$clog2(TIMER_SLOTS + 1)-1:0] count_o
);

  localparam int unsigned SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned TB     = stt_pkg::TIME_BITS;
  localparam int unsigned IW     = stt_pkg::ID_W;
  localparam int unsigned DW     = stt_pkg::DELAY_W;

  // Held input item.
  stt_pkg::opcode_e op_q;
  logic [TB-1:0]    now_q;
  logic [DW-1:0]    delay_q;
  logic [DW-1:0]    interval_q;
  logic [IW-1:0]    target_q;

  // Table control.
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IW-1:0]          next_id_q, next_id_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]       wptr_q, wptr_d;
  logic [TIMER_SLOTS-1:0] gone_q, gone_d;
  logic                   gone_any_q, gone_any_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [IW-1:0]          pend_id_q, pend_id_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  stt_pkg::kind_e         out_kind_q, out_kind_d;
  logic [IW-1:0]          out_id_q, out_id_d;
  logic                   out_last_q, out_last_d;

  // RAM ports.
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  stt_pkg::entry_t        wr_entry;
  stt_pkg::entry_t        rd_entry;
  logic [$bits(stt_pkg::entry_t)-1:0] rd_raw;

  logic          is_tick;
  logic          due;
  logic [TB-1:0] reload;
  logic          out_free;
  logic          keep;

  stt_ram #(
    .WIDTH ($bits(stt_pkg::entry_t)),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_raw)
  );

  assign rd_entry = stt_pkg::entry_t'(rd_raw);
  assign is_tick  = (op_q == stt_pkg::OP_TICK);
  assign due      = (now_q >= rd_entry.deadline);
  assign reload   = stt_pkg::sat_add(now_q, rd_entry.interval);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign keep     = !gone_q[idx_q];

  always_comb begin
    count_d      = count_q;
    next_id_d    = next_id_q;
    idx_d        = idx_q;
    wptr_d       = wptr_q;
    gone_d       = gone_q;
    gone_any_d   = gone_any_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_entry     = rd_entry;

    if (cmd_i.latch) begin
      pend_valid_d = 1'b0;
    end

    if (cmd_i.add_full) begin
      out_valid_d = 1'b1;
      out_kind_d  = stt_pkg::KIND_FULL;
      out_id_d    = '0;
      out_last_d  = 1'b1;
    end

    if (cmd_i.add_commit) begin
      wr_en             = 1'b1;
      wr_addr           = count_q[SLOT_W-1:0];
      wr_entry.id       = next_id_q;
      wr_entry.deadline = stt_pkg::sat_add(now_q, delay_q);
      wr_entry.interval = interval_q;
      count_d           = count_q + CNT_W'(1);
      next_id_d         = next_id_q + IW'(1);
      out_valid_d       = 1'b1;
      out_kind_d        = stt_pkg::KIND_ADDED;
      out_id_d          = next_id_q;
      out_last_d        = 1'b1;
    end

    if (cmd_i.clear_all) begin
      count_d     = '0;
      out_valid_d = 1'b1;
      out_kind_d  = stt_pkg::KIND_CANCELLED;
      out_id_d    = '0;
      out_last_d  = 1'b1;
    end

    if (cmd_i.scan_init) begin
      idx_d      = SLOT_W'(count_q - CNT_W'(1));
      gone_d     = '0;
      gone_any_d = 1'b0;
    end

    if (cmd_i.mark_step) begin
      if (is_tick) begin
        if (due) begin
          // The previously held firing is now known not to be the final one.
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = stt_pkg::KIND_FIRED;
            out_id_d    = pend_id_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_id_d    = rd_entry.id;
          if (rd_entry.interval != '0) begin
            wr_en             = 1'b1;
            wr_entry.deadline = reload;
          end else begin
            gone_d[idx_q] = 1'b1;
            gone_any_d    = 1'b1;
          end
        end
      end else if (rd_entry.id == target_q) begin
        gone_d[idx_q] = 1'b1;
        gone_any_d    = 1'b1;
      end
      if (idx_q != '0) begin
        idx_d = idx_q - SLOT_W'(1);
      end
    end

    if (cmd_i.pack_init) begin
      idx_d  = '0;
      wptr_d = '0;
    end

    if (cmd_i.pack_step) begin
      if (keep) begin
        wr_en   = 1'b1;
        wr_addr = wptr_q[SLOT_W-1:0];
        wptr_d  = wptr_q + CNT_W'(1);
      end
      if (sts_o.idx_top) begin
        count_d = wptr_q + CNT_W'(keep);
      end else begin
        idx_d = idx_q + SLOT_W'(1);
      end
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      if (!is_tick) begin
        out_kind_d = stt_pkg::KIND_CANCELLED;
        out_id_d   = target_q;
      end else if (pend_valid_q) begin
        out_kind_d = stt_pkg::KIND_FIRED;
        out_id_d   = pend_id_q;
      end else begin
        out_kind_d = stt_pkg::KIND_IDLE;
        out_id_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      next_id_q    <= '0;
      idx_q        <= '0;
      wptr_q       <= '0;
      gone_q       <= '0;
      gone_any_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      idx_q        <= idx_d;
      wptr_q       <= wptr_d;
      gone_q       <= gone_d;
      gone_any_q   <= gone_any_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= stt_pkg::opcode_e'(s_axis_tuser_i);
      now_q      <= s_axis_tdata_i[TB-1:0];
      delay_q    <= s_axis_tdata_i[TB+DW-1:TB];
      interval_q <= s_axis_tdata_i[TB+2*DW-1:TB+DW];
      target_q   <= s_axis_tdata_i[TB+2*DW+IW-1:TB+2*DW];
    end
    pend_id_q  <= pend_id_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.out_free   = out_free;
    sts_o.count_zero = (count_q == '0);
    sts_o.count_full = (count_q == CNT_W'(TIMER_SLOTS));
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.idx_top    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
    sts_o.gone_any   = gone_any_q;
    sts_o.mark_stall = is_tick && due && pend_valid_q && !out_free;
  end

  assign count_o         = count_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_id_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### sv/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// Software timer table: top level
// Table of one-shot and periodic timers driven by add, cancel and tick items.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the slave stream: tuser carries the opcode (add,
// cancel by identifier, cancel all, tick) and tdata the time and arguments.
// Results leave on the master stream: tuser is the result kind, tdata the
// timer identifier, and tlast marks the final result of a command. Add,
// cancel and cancel-all give one result each; a tick gives one result per
// fired timer, in reverse table order, or a single idle result.
// Sequencing: an add or cancel-all result is loaded into the output register
// from the dispatch state that follows its transfer, after which the
// sequencer returns to idle for the next transfer. A cancel or a tick runs
// a marking scan over the table and, when entries were removed, a compaction
// pass that writes the kept entries back in order; both passes go through
// the single read port of the table RAM, with a read and an evaluate state
// per entry. One command is worked on at a time; the next transfer is taken
// once the previous one has handed its last result to the output register.
// A stalled receiver holds the output register and the sequencer waits on it;
// no result is lost. After reset the table is empty and identifiers start at
// zero; the table RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "software_timer_table_top_defines.svh"

module software_timer_table_top #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Command stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // now_ms [47:0], delay_ms [79:48], interval_ms [111:80], target_id [143:112]
  input  logic [143:0] s_axis_tdata_i,
  // opcode [1:0]
  input  logic [1:0]   s_axis_tuser_i,
  // Result stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_id [31:0]
  output logic [31:0]  m_axis_tdata_o,
  // result_kind [2:0]
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;
  logic [$clog2(TIMER_SLOTS + 1)-1:0] count;
  logic out_load;
  logic in_xfer;

  stt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  stt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .count_o         (count)
  );

  // Commands that load a final or single result into the output register.
  assign out_load = cmd.add_commit || cmd.add_full || cmd.clear_all || cmd.finish;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  // A command that loads the output register is only issued when it is free.
  `STT_ASSERT_SAME(a_emit_free, out_load, sts.out_free, "result loaded over a pending result")
  // The table never holds more entries than it has slots.
  `STT_ASSERT_SAME(a_count_bound, 1'b1, count <= TIMER_SLOTS, "entry count beyond table size")
  // A command is worked on alone: no second transfer right after one.
  `STT_ASSERT_NEXT(a_one_cmd, in_xfer, !s_axis_tready_o, "command taken while busy")

endmodule

### tb/tb_software_timer_table_top.sv
// ----------------------------------------------------------------------------
// Software timer table: testbench
// Streams add, cancel, cancel-all and tick commands into the timer table and
// checks each result transfer against a timer table that is modelled here.
// ----------------------------------------------------------------------------
module tb_software_timer_table_top;

  localparam int SLOTS       = 16;
  // Cycles without any transfer on either stream before the run is abandoned.
  // The slowest command is a tick that fires and compacts a full table, and a
  // slow receiver adds its stalls on top of it.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles at the end, so that any stray extra result is still seen.
  localparam int SETTLE      = 120;

  typedef logic [stt_pkg::TIME_BITS-1:0] ms_t;

  localparam ms_t TIME_MAX = '1;

  typedef struct {
    stt_pkg::opcode_e op;
    ms_t              now_ms;
    logic [31:0]      delay_ms;
    logic [31:0]      interval_ms;
    logic [31:0]      target_id;
  } timer_cmd_t;

  typedef struct {
    stt_pkg::kind_e kind;
    logic [31:0]    id;
    logic           last;
  } timer_result_t;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i  = '0;
  logic [1:0]   s_axis_tuser_i  = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  software_timer_table_top #(
    .TIMER_SLOTS (SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Modelled timer table, updated when a command transfer is accepted.
  logic [31:0]          tbl_id       [SLOTS];
  ms_t                  tbl_deadline [SLOTS];
  logic [31:0]          tbl_interval [SLOTS];
  int                   tbl_count     = 0;
  logic [31:0]          next_timer_id = '0;

  timer_cmd_t           pending_cmds[$];
  timer_cmd_t           cmd_on_bus;
  timer_result_t        awaited_results[$];
  int                   mismatches    = 0;
  int                   stall_cycles  = 0;
  int                   send_gap_pct  = 0;
  int                   recv_gap_pct  = 0;
  // Time base of the well-formed random traffic.
  ms_t                  wall_ms       = '0;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Deadline that lies an offset after a time, held at the top of the range.
  function automatic ms_t deadline_after(ms_t t, logic [31:0] offset);
    ms_t wide;
    wide = ms_t'(offset);
    if (wide > TIME_MAX - t) return TIME_MAX;
    return t + wide;
  endfunction

  task automatic await_result(stt_pkg::kind_e kind, logic [31:0] id, logic last);
    timer_result_t r;
    r.kind = kind;
    r.id   = id;
    r.last = last;
    awaited_results = {awaited_results, r};
  endtask

  // Removes the marked entries and closes the gaps, keeping insertion order.
  task automatic drop_entries(logic [SLOTS-1:0] gone);
    int keep;
    keep = 0;
    for (int r = 0; r < tbl_count; r++) begin
      if (!gone[r]) begin
        tbl_id[keep]       = tbl_id[r];
        tbl_deadline[keep] = tbl_deadline[r];
        tbl_interval[keep] = tbl_interval[r];
        keep++;
      end
    end
    tbl_count = keep;
  endtask

  // Applies one accepted command to the modelled table and queues the
  // results that it must produce.
  task automatic apply_command(timer_cmd_t c);
    logic [SLOTS-1:0] gone;
    logic [SLOTS-1:0] due;
    int               due_count;
    int               fired;
    gone      = '0;
    due       = '0;
    due_count = 0;
    fired     = 0;
    unique case (c.op)
      stt_pkg::OP_ADD: begin
        if (tbl_count == SLOTS) begin
          await_result(stt_pkg::KIND_FULL, '0, 1'b1);
        end else begin
          tbl_id[tbl_count]       = next_timer_id;
          tbl_deadline[tbl_count] = deadline_after(c.now_ms, c.delay_ms);
          tbl_interval[tbl_count] = c.interval_ms;
          tbl_count++;
          await_result(stt_pkg::KIND_ADDED, next_timer_id, 1'b1);
          next_timer_id++;
        end
      end
      stt_pkg::OP_CANCEL: begin
        for (int i = 0; i < tbl_count; i++) gone[i] = (tbl_id[i] == c.target_id);
        drop_entries(gone);
        await_result(stt_pkg::KIND_CANCELLED, c.target_id, 1'b1);
      end
      stt_pkg::OP_CLEAR: begin
        tbl_count = 0;
        await_result(stt_pkg::KIND_CANCELLED, '0, 1'b1);
      end
      default: begin
        // The due set is fixed before any reload, so nothing fires twice.
        for (int i = 0; i < tbl_count; i++) begin
          if (c.now_ms >= tbl_deadline[i]) begin
            due[i] = 1'b1;
            due_count++;
          end
        end
        for (int k = tbl_count - 1; k >= 0; k--) begin
          if (due[k]) begin
            fired++;
            await_result(stt_pkg::KIND_FIRED, tbl_id[k], fired == due_count);
            if (tbl_interval[k] != 0) begin
              tbl_deadline[k] = deadline_after(c.now_ms, tbl_interval[k]);
            end else begin
              gone[k] = 1'b1;
            end
          end
        end
        drop_entries(gone);
        if (due_count == 0) await_result(stt_pkg::KIND_IDLE, '0, 1'b1);
      end
    endcase
  endtask

  // Command driver. A command is applied to the model on the edge where its
  // transfer happens; the next one is put on the bus in the same step, unless
  // the sender chooses to idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) apply_command(cmd_on_bus);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cmd_on_bus = pending_cmds.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= cmd_on_bus.op;
          s_axis_tdata_i  <= {cmd_on_bus.target_id, cmd_on_bus.interval_ms,
                              cmd_on_bus.delay_ms, cmd_on_bus.now_ms};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_gap_pct);

  // Result checker: every result transfer is matched with the oldest
  // outstanding expectation.
  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0h",
                                  m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser_o !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser_o, want.kind));
        if (m_axis_tdata_o !== want.id)
          report_mismatch($sformatf("id %0h, expected %0h", m_axis_tdata_o, want.id));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast_o, want.last));
      end
    end
  end

  // Watchdog on progress: any transfer on either stream restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("** software_timer_table_top: FAILED **");
      $finish;
    end
  end

  // Queues one command for the driver, keeping a few ahead of the bus so
  // that back-to-back transfers are possible.
  task automatic send_command(stt_pkg::opcode_e op, ms_t now_ms,
                              logic [31:0] delay_ms, logic [31:0] interval_ms,
                              logic [31:0] target_id);
    timer_cmd_t c;
    c.op          = op;
    c.now_ms      = now_ms;
    c.delay_ms    = delay_ms;
    c.interval_ms = interval_ms;
    c.target_id   = target_id;
    while (pending_cmds.size() >= 4) @(posedge clk_i);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic wait_until_quiet();
    while (pending_cmds.size() != 0 || s_axis_tvalid_i || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  // A tick on an empty table is idle, and a cancel that matches nothing
  // still reports completion.
  task automatic test_empty_table();
    send_command(stt_pkg::OP_TICK, '0, '0, '0, '0);
    send_command(stt_pkg::OP_CANCEL, '0, '0, '0, 32'hFFFF_FFFF);
  endtask

  // A one-shot timer fires once and goes; a periodic one reloads from the
  // time of the tick and is not fired twice by the same tick.
  task automatic test_one_shot_and_periodic();
    send_command(stt_pkg::OP_ADD, '0, 32'd0, 32'd0, '0);
    send_command(stt_pkg::OP_ADD, '0, 32'd5, 32'd10, '0);
    send_command(stt_pkg::OP_TICK, '0, '0, '0, '0);
    send_command(stt_pkg::OP_TICK, 48'd5, '0, '0, '0);
    send_command(stt_pkg::OP_TICK, 48'd5, '0, '0, '0);
  endtask

  // Deadlines near the top of the time range stick at the largest value.
  task automatic test_saturation();
    send_command(stt_pkg::OP_ADD, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_command(stt_pkg::OP_TICK, TIME_MAX, '0, '0, '0);
    send_command(stt_pkg::OP_TICK, TIME_MAX, '0, '0, '0);
  endtask

  // Fills the table, overflows it once, then fires every entry in one tick,
  // with one-shot and periodic entries interleaved.
  task automatic test_table_full();
    for (int i = 0; i < SLOTS - 2; i++)
      send_command(stt_pkg::OP_ADD, 48'd100, 32'(i), (i % 2 != 0) ? 32'd7 : 32'd0, '0);
    send_command(stt_pkg::OP_ADD, 48'd100, 32'd1, 32'd1, '0);
    send_command(stt_pkg::OP_TICK, TIME_MAX, '0, '0, '0);
  endtask

  task automatic test_cancel();
    send_command(stt_pkg::OP_CANCEL, '0, '0, '0, 32'd1);
    send_command(stt_pkg::OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Mostly well-formed traffic on a rising clock with short delays, so that
  // timers are added, fire, reload and get cancelled; the rest is noise with
  // every field random. Most fields a command ignores carry random values.
  task automatic test_random_traffic(int count);
    ms_t         rand_now;
    logic [31:0] interval_ms;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 15) begin
        rand_now = ms_t'({$urandom(), $urandom()});
        send_command(stt_pkg::opcode_e'($urandom_range(3)), rand_now,
                     $urandom, $urandom, $urandom);
      end else if (pick < 35) begin
        interval_ms = ($urandom_range(1) != 0) ? $urandom_range(30, 1) : 32'd0;
        send_command(stt_pkg::OP_ADD, wall_ms, $urandom_range(40), interval_ms, $urandom);
      end else if (pick < 50) begin
        rand_now = ms_t'({$urandom(), $urandom()});
        send_command(stt_pkg::OP_CANCEL, rand_now, $urandom, $urandom,
                     next_timer_id - $urandom_range(8, 1));
      end else if (pick < 53) begin
        send_command(stt_pkg::OP_CLEAR, wall_ms, $urandom, $urandom, $urandom);
      end else begin
        wall_ms = wall_ms + ms_t'($urandom_range(15));
        send_command(stt_pkg::OP_TICK, wall_ms, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct = 22;
    recv_gap_pct = 54;
    test_empty_table();
    test_one_shot_and_periodic();
    test_saturation();
    test_table_full();
    test_cancel();
    wall_ms = ms_t'($urandom_range(1000));
    test_random_traffic(40);

    send_gap_pct = 54;
    recv_gap_pct = 22;
    test_random_traffic(40);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(40);

    wait_until_quiet();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** software_timer_table_top: PASSED **");
    end else begin
      $display("** software_timer_table_top: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_ctrl.sv
sv/stt_datapath.sv
sv/software_timer_table_top.sv
tb/tb_software_timer_table_top.sv
